FILE: design/srtf_pkg.sv
// Shared types and constants for the SRTF scheduler.
// Used by srtf_ctrl, srtf_dp and srtf_scheduler; depends on nothing else.
package srtf_pkg;

    localparam int MAX_PROCESSES_DEF = 64;
    localparam int BURST_W           = 16;
    localparam int TIME_W            = 32;
    localparam int SUM_W             = 38;
    localparam int IDX_OUT_W         = 6;

    // Function codes of an input transfer
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // One process table entry
    typedef struct packed {
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_UPDATE,
        ST_WAIT,
        ST_TURN,
        ST_SUM,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic pick;
        logic update;
        logic calc_wait;
        logic calc_turn;
        logic sum;
        logic time_inc;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic last_unit;
        logic out_free;
    } t_status;

endpackage

FILE: design/srtf_ctrl.sv
// Sequencer for the SRTF scheduler: load, scan, pick, update, completion math, emit.
// Depends on srtf_pkg; drives the datapath srtf_dp through t_cmd.
module srtf_ctrl import srtf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_func,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall,
    output t_state  o_state
);

    t_state r_state;
    t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_func == FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_EMIT;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
                if (i_status.found) begin
                    n_state = ST_UPDATE;
                end else begin
                    o_cmd.time_inc = 1'b1;
                    n_state        = ST_EMIT;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_status.last_unit) begin
                    n_state = ST_WAIT;
                end else begin
                    o_cmd.time_inc = 1'b1;
                    n_state        = ST_EMIT;
                end
            end
            ST_WAIT: begin
                o_cmd.calc_wait = 1'b1;
                n_state         = ST_TURN;
            end
            ST_TURN: begin
                o_cmd.calc_turn = 1'b1;
                n_state         = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum      = 1'b1;
                o_cmd.time_inc = 1'b1;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

FILE: design/srtf_dp.sv
// Datapath of the SRTF scheduler: process table memory, serial minimum scan,
// completion arithmetic, running sums and the output register. Depends on srtf_pkg.
module srtf_dp import srtf_pkg::*; #(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [BURST_W-1:0]   i_burst,
    input  logic [TIME_W-1:0]    i_arrival,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic                 o_accepted,
    output logic                 o_ran,
    output logic [IDX_OUT_W-1:0] o_process_index,
    output logic                 o_finished,
    output logic [TIME_W-1:0]    o_waiting,
    output logic [TIME_W-1:0]    o_turnaround,
    output logic                 o_all_done,
    output logic [SUM_W-1:0]     o_wait_sum,
    output logic [SUM_W-1:0]     o_turn_sum
);

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    // Process table
    t_entry r_mem [MAX_PROCESSES];
    t_entry r_rd_data;

    logic [CNT_W-1:0]  r_process_count;
    logic [CNT_W-1:0]  r_done_count;
    logic [TIME_W-1:0] r_time;

    // Scan state
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_addr;
    logic             r_found;
    logic [IDX_W-1:0] r_best_idx;
    t_entry           r_best;
    logic             r_run_ok;
    t_entry           r_run;
    logic [IDX_W-1:0] r_run_slot;
    logic             r_run_valid;

    // Completion arithmetic
    logic [TIME_W:0]   r_fin;
    logic [TIME_W:0]   r_sub;
    logic [TIME_W:0]   r_wait;
    logic [TIME_W-1:0] r_turn;
    logic [SUM_W-1:0]  r_wait_total;
    logic [SUM_W-1:0]  r_turn_total;

    // Result being built
    logic                 r_res_accepted;
    logic                 r_res_ran;
    logic [IDX_OUT_W-1:0] r_res_idx;
    logic                 r_res_finished;
    logic [TIME_W-1:0]    r_res_wait;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_accepted;
    logic                 r_out_ran;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic                 r_out_finished;
    logic [TIME_W-1:0]    r_out_wait;
    logic [TIME_W-1:0]    r_out_turn;
    logic                 r_out_all_done;
    logic [SUM_W-1:0]     r_out_wait_sum;
    logic [SUM_W-1:0]     r_out_turn_sum;

    logic               table_full;
    logic               rd_issue;
    logic               rd_ready;
    logic               rd_better;
    logic               run_tie;
    logic [BURST_W-1:0] rem_dec;
    logic [TIME_W+1:0]  turn_full;
    logic [SUM_W:0]     wait_acc;
    logic [SUM_W:0]     turn_acc;

    assign table_full = (r_process_count == CNT_W'(MAX_PROCESSES));
    assign rd_issue   = i_cmd.scan_step && (r_rd_idx < r_process_count);
    assign rd_ready   = (r_rd_data.remaining != '0) && (r_rd_data.arrival <= r_time);
    assign rd_better  = rd_ready && (!r_found || (r_rd_data.remaining < r_best.remaining));
    assign run_tie    = r_run_ok && r_found && (r_run.remaining == r_best.remaining);
    assign rem_dec    = r_best.remaining - BURST_W'(1);
    assign turn_full  = {1'b0, r_wait} + (TIME_W + 2)'(r_best.burst);
    assign wait_acc   = {1'b0, r_wait_total} + (SUM_W + 1)'(r_res_wait);
    assign turn_acc   = {1'b0, r_turn_total} + (SUM_W + 1)'(r_turn);

    assign o_status.scan_done = (r_rd_idx >= r_process_count) && !r_rd_vld;
    assign o_status.found     = r_found;
    assign o_status.last_unit = (r_best.remaining == BURST_W'(1));
    assign o_status.out_free  = !r_out_valid || !i_stall;

    // Write loads and decrements; read one entry per scan cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !table_full) begin
            r_mem[r_process_count[IDX_W-1:0]] <= '{remaining: i_burst, burst: i_burst,
                                                  arrival: i_arrival};
        end else if (i_cmd.update) begin
            r_mem[r_best_idx] <= '{remaining: rem_dec, burst: r_best.burst,
                                   arrival: r_best.arrival};
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    // Scan control: advance the read index, track the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_rd_vld <= rd_issue;
            if (rd_issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_addr <= r_rd_idx[IDX_W-1:0];
        end
    end

    // Keep the best candidate and the running process's entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_run_ok <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_found  <= 1'b0;
            r_run_ok <= 1'b0;
        end else if (i_cmd.scan_step && r_rd_vld) begin
            if (rd_better) begin
                r_found <= 1'b1;
            end
            if (r_run_valid && (r_rd_addr == r_run_slot)) begin
                r_run_ok <= rd_ready;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && r_rd_vld) begin
            if (rd_better) begin
                r_best     <= r_rd_data;
                r_best_idx <= r_rd_addr;
            end
            if (r_rd_addr == r_run_slot) begin
                r_run <= r_rd_data;
            end
        end else if (i_cmd.pick && run_tie) begin
            // Running process keeps the processor on a tie
            r_best     <= r_run;
            r_best_idx <= r_run_slot;
        end
    end

    // Counters, time, running process, totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_count <= '0;
            r_done_count    <= '0;
            r_time          <= '0;
            r_run_valid     <= 1'b0;
            r_run_slot      <= '0;
            r_wait_total    <= '0;
            r_turn_total    <= '0;
        end else begin
            if (i_cmd.load && !table_full) begin
                r_process_count <= r_process_count + CNT_W'(1);
                if (i_burst == '0) begin
                    r_done_count <= r_done_count + CNT_W'(1);
                end
            end
            if (i_cmd.update) begin
                r_run_slot  <= r_best_idx;
                r_run_valid <= 1'b1;
            end
            if (i_cmd.sum) begin
                r_done_count <= r_done_count + CNT_W'(1);
                r_run_valid  <= 1'b0;
                r_wait_total <= wait_acc[SUM_W] ? '1 : wait_acc[SUM_W-1:0];
                r_turn_total <= turn_acc[SUM_W] ? '1 : turn_acc[SUM_W-1:0];
            end
            if (i_cmd.time_inc) begin
                r_time <= r_time + TIME_W'(1);
            end
        end
    end

    // Completion math: finish and subtrahend, clamped wait, saturated turnaround
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_fin <= {1'b0, r_time} + (TIME_W + 1)'(1);
            r_sub <= (TIME_W + 1)'(r_best.burst) + {1'b0, r_best.arrival};
        end
        if (i_cmd.calc_wait) begin
            r_wait <= (r_fin > r_sub) ? (r_fin - r_sub) : '0;
        end
        if (i_cmd.calc_turn) begin
            r_turn <= (turn_full[TIME_W+1:TIME_W] != 2'b00) ? '1 : turn_full[TIME_W-1:0];
        end
    end

    // Build the result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.scan_start) begin
            r_res_accepted <= i_cmd.load && !table_full;
            r_res_ran      <= 1'b0;
            r_res_idx      <= '0;
            r_res_finished <= 1'b0;
            r_res_wait     <= '0;
        end else begin
            if (i_cmd.update) begin
                r_res_ran <= 1'b1;
                r_res_idx <= IDX_OUT_W'(r_best_idx);
            end
            if (i_cmd.calc_turn) begin
                r_res_wait <= r_wait[TIME_W-1:0];
            end
            if (i_cmd.sum) begin
                r_res_finished <= 1'b1;
            end
        end
    end

    // Output register: load on emit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_accepted <= r_res_accepted;
            r_out_ran      <= r_res_ran;
            r_out_idx      <= r_res_idx;
            r_out_finished <= r_res_finished;
            r_out_wait     <= r_res_finished ? r_res_wait : '0;
            r_out_turn     <= r_res_finished ? r_turn : '0;
            r_out_all_done <= (r_done_count == r_process_count);
            r_out_wait_sum <= r_wait_total;
            r_out_turn_sum <= r_turn_total;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_accepted      = r_out_accepted;
    assign o_ran           = r_out_ran;
    assign o_process_index = r_out_idx;
    assign o_finished      = r_out_finished;
    assign o_waiting       = r_out_wait;
    assign o_turnaround    = r_out_turn;
    assign o_all_done      = r_out_all_done;
    assign o_wait_sum      = r_out_wait_sum;
    assign o_turn_sum      = r_out_turn_sum;

endmodule

FILE: design/srtf_scheduler.sv
// Preemptive shortest-remaining-time-first scheduler. A load (func 0) stores one
// process in the next free slot; a load into a full table is
// refused. A tick (func 1) reads the process table serially, one entry per cycle from
// a single-port memory, then either advances time when nothing is ready, runs the
// chosen process one unit, or completes it and computes its wait and turnaround.
// A stalled output register holds the sequencer in its emit state until it drains.
// One item is worked on at a time; the finished result sits in an output
// register, so the next item is taken while it waits for the downstream side.
// Depends on srtf_pkg, srtf_ctrl and srtf_dp.
module srtf_scheduler import srtf_pkg::*; #(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_func,
    input  logic [BURST_W-1:0]   i_burst,
    input  logic [TIME_W-1:0]    i_arrival,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_accepted,
    output logic                 o_ran,
    output logic [IDX_OUT_W-1:0] o_process_index,
    output logic                 o_finished,
    output logic [TIME_W-1:0]    o_waiting,
    output logic [TIME_W-1:0]    o_turnaround,
    output logic                 o_all_done,
    output logic [SUM_W-1:0]     o_wait_sum,
    output logic [SUM_W-1:0]     o_turn_sum
);

    t_cmd    cmd;
    t_status status;
    t_state  state;

    // Sequencer
    srtf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_state  (state)
    );

    // Table, scan and arithmetic
    srtf_dp #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_burst         (i_burst),
        .i_arrival       (i_arrival),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_accepted      (o_accepted),
        .o_ran           (o_ran),
        .o_process_index (o_process_index),
        .o_finished      (o_finished),
        .o_waiting       (o_waiting),
        .o_turnaround    (o_turnaround),
        .o_all_done      (o_all_done),
        .o_wait_sum      (o_wait_sum),
        .o_turn_sum      (o_turn_sum)
    );

    // A transfer in moves the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (state != ST_IDLE))
        else $error("sequencer stayed idle after an input transfer");

    // A finished process must have run, and a load never runs one
    a_finish_implies_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (o_ran && !o_accepted))
        else $error("completion reported without a run");

    // Turnaround never falls below the waiting time
    a_turn_ge_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (o_turnaround >= o_waiting))
        else $error("turnaround below waiting time");

    // Emit is issued only when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted over a pending output");

endmodule
